@@ rtl/pbc_pkg.sv @@
// Package for the page buffer cache: slot count, field widths, sequencer states.
// No dependencies; imported by page_buffer_cache and the testbench.
`default_nettype none

package pbc_pkg;

  localparam int SLOTS     = 64;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LEFT_W    = $clog2(SLOTS + 1);
  localparam int TAG_W     = 32;
  localparam int SLOT_ID_W = 6;
  localparam int OUT_TDATA_W = ((SLOT_ID_W + 7) / 8) * 8;

  localparam logic ACT_LOOKUP   = 1'b0;
  localparam logic ACT_ALLOCATE = 1'b1;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUSH
  } pbc_state_t;

  function automatic slot_t slot_inc(input slot_t s);
    slot_inc = (s == slot_t'(SLOTS - 1)) ? '0 : slot_t'(s + 1'b1);
  endfunction

  function automatic logic [SLOT_ID_W-1:0] to_slot_id(input slot_t s);
    to_slot_id = SLOT_ID_W'(s);
  endfunction

endpackage

`default_nettype wire

@@ rtl/pbc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [$clog2(DEPTH)-1:0]       waddr,
  input  wire logic [WIDTH-1:0]               wdata,
  input  wire logic [$clog2(DEPTH)-1:0]       raddr,
  output logic      [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/page_buffer_cache.sv @@
// Page buffer cache top level: tag RAM, valid bits, allocation pointer, scan sequencer.
// Depends on pbc_pkg and pbc_ram.
`default_nettype none

// Maps 32-bit logical page numbers to buffer slots. Each input transaction
// either allocates (in_tuser = 1) or looks up (in_tuser = 0) a page. An
// allocate takes the next slot in round-robin order, with no duplicate check,
// and always answers found = 1 with the slot given. A lookup compares the
// page against the tag RAM one slot per cycle with a single comparator,
// starting at the oldest slot, and answers the first valid match (found = 1)
// or found = 0 with slot_id 0. Hits do not change the replacement order.
// An allocate goes straight to the push state; a lookup's scan length is
// set by the one-read-per-cycle tag RAM port feeding the comparator, so it
// reads up to SLOTS slots. One transaction is worked on at a time; the
// finished result sits in an output register, so the next input transaction
// is taken while the result waits for out_tready.
module page_buffer_cache
  import pbc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input channel
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [TAG_W-1:0]       in_tdata,   // [31:0] page_number
  input  wire logic                   in_tuser,   // [0] action
  // result channel
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [5:0] slot_id, rest zero
  output logic                        out_tuser   // [0] found
);

  pbc_state_t state_r, state_nxt;

  logic [SLOTS-1:0]     valid_r, valid_nxt;
  slot_t                next_slot_r, next_slot_nxt;
  logic                 all_used_r, all_used_nxt;

  logic [TAG_W-1:0]     page_r, page_nxt;
  slot_t                scan_slot_r, scan_slot_nxt;
  logic [LEFT_W-1:0]    left_r, left_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  slot_t                cmp_slot_r, cmp_slot_nxt;
  logic                 cmp_last_r, cmp_last_nxt;

  logic                 res_found_r, res_found_nxt;
  slot_t                res_slot_r, res_slot_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [SLOT_ID_W-1:0] out_slot_r, out_slot_nxt;

  logic                 ram_we;
  logic [TAG_W-1:0]     ram_rdata;
  logic                 in_acc;
  logic                 out_free;
  logic                 hit;

  pbc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (SLOTS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (next_slot_r),
    .wdata (in_tdata),
    .raddr (scan_slot_r),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign hit        = cmp_vld_r && valid_r[cmp_slot_r] && (ram_rdata == page_r);

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = OUT_TDATA_W'(out_slot_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      next_slot_r <= '0;
      all_used_r  <= 1'b0;
      left_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      next_slot_r <= next_slot_nxt;
      all_used_r  <= all_used_nxt;
      left_r      <= left_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r      <= page_nxt;
    scan_slot_r <= scan_slot_nxt;
    cmp_slot_r  <= cmp_slot_nxt;
    cmp_last_r  <= cmp_last_nxt;
    res_found_r <= res_found_nxt;
    res_slot_r  <= res_slot_nxt;
    out_found_r <= out_found_nxt;
    out_slot_r  <= out_slot_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    next_slot_nxt = next_slot_r;
    all_used_nxt  = all_used_r;
    page_nxt      = page_r;
    scan_slot_nxt = scan_slot_r;
    left_nxt      = left_r;
    cmp_vld_nxt   = 1'b0;
    cmp_slot_nxt  = cmp_slot_r;
    cmp_last_nxt  = cmp_last_r;
    res_found_nxt = res_found_r;
    res_slot_nxt  = res_slot_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_slot_nxt  = out_slot_r;
    ram_we        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          page_nxt = in_tdata;
          if (in_tuser == ACT_ALLOCATE) begin
            // write tag at the allocation pointer, then advance it
            ram_we                 = 1'b1;
            valid_nxt[next_slot_r] = 1'b1;
            res_found_nxt          = 1'b1;
            res_slot_nxt           = next_slot_r;
            next_slot_nxt          = slot_inc(next_slot_r);
            if (next_slot_r == slot_t'(SLOTS - 1)) begin
              all_used_nxt = 1'b1;
            end
            state_nxt = ST_PUSH;
          end else begin
            // oldest slot is the pointer once every slot has been used
            scan_slot_nxt = all_used_r ? next_slot_r : '0;
            left_nxt      = LEFT_W'(SLOTS);
            state_nxt     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (left_r != '0) begin
          cmp_vld_nxt   = 1'b1;
          cmp_slot_nxt  = scan_slot_r;
          cmp_last_nxt  = (left_r == LEFT_W'(1));
          scan_slot_nxt = slot_inc(scan_slot_r);
          left_nxt      = left_r - 1'b1;
        end
        if (hit) begin
          res_found_nxt = 1'b1;
          res_slot_nxt  = cmp_slot_r;
          left_nxt      = '0;
          cmp_vld_nxt   = 1'b0;
          state_nxt     = ST_PUSH;
        end else if (cmp_vld_r && cmp_last_r) begin
          res_found_nxt = 1'b0;
          res_slot_nxt  = '0;
          cmp_vld_nxt   = 1'b0;
          state_nxt     = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_slot_nxt  = to_slot_id(res_slot_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // a compare in flight only exists while scanning
  a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> state_r == ST_SCAN)
    else $error("compare pending outside scan");

  // the scan always has a read left or a compare pending, so it cannot stall
  a_scan_progress: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> (left_r != '0 || cmp_vld_r))
    else $error("scan stalled with nothing to compare");

  // an allocate advances the pointer by one slot and marks the slot valid
  a_alloc_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == ACT_ALLOCATE) |=>
      (next_slot_r == slot_inc($past(next_slot_r)) && valid_r[$past(next_slot_r)]))
    else $error("allocation pointer or valid bit wrong");

  // a finished result moves to the output register once it is free
  a_push_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not loaded into output register");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for page_buffer_cache: directed and random lookup/allocate traffic.
// Depends on pbc_pkg and the page_buffer_cache RTL; keeps its own slot map to predict results.
`timescale 1ns / 100ps

module tb;
  import pbc_pkg::*;

  // Watchdog. The slowest correct run is about 1100 transactions, each taking
  // at most a full scan plus the longest sender gap and receiver stall.
  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_DEPTH  = 48;

  // One expected result: found travels on out_tuser, slot_id in out_tdata.
  typedef struct packed {
    logic                 found;
    logic [SLOT_ID_W-1:0] slot_id;
  } slot_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [TAG_W-1:0]       in_tdata;   // [31:0] page_number
  logic                   in_tuser;   // [0] action
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [5:0] slot_id, rest zero
  logic                   out_tuser;  // [0] found

  // Shadow slot map: tags, occupancy, allocation pointer, wrap flag.
  logic [TAG_W-1:0] tag_copy [SLOTS];
  bit               held     [SLOTS];
  int unsigned      alloc_ptr;
  bit               wrapped;

  slot_result_t     pending_results [$];
  logic [TAG_W-1:0] page_pool [POOL_DEPTH];

  bit src_gaps;     // sender inserts idle bursts
  bit sink_stalls;  // receiver drops tready in bursts
  int error_count;
  int n_lookup;
  int n_alloc;
  int n_hit;
  int cycle_count;

  page_buffer_cache DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Advance the shadow map by one accepted transaction and return what the
  // block must answer. Allocate: take alloc_ptr, no duplicate check. Lookup:
  // scan from the oldest slot (slot 0 until the first wrap, then alloc_ptr)
  // and report the first occupied slot whose tag matches.
  function automatic slot_result_t predict_slot(input logic act,
                                                input logic [TAG_W-1:0] page);
    slot_result_t r;
    int unsigned  oldest;
    int unsigned  s;
    r.found   = 1'b0;
    r.slot_id = '0;
    if (act == ACT_ALLOCATE) begin
      tag_copy[alloc_ptr] = page;
      held[alloc_ptr]     = 1'b1;
      r.found             = 1'b1;
      r.slot_id           = SLOT_ID_W'(alloc_ptr);
      if (alloc_ptr == SLOTS - 1) begin
        alloc_ptr = 0;
        wrapped   = 1'b1;
      end else begin
        alloc_ptr++;
      end
    end else begin
      oldest = wrapped ? alloc_ptr : 0;
      for (int k = 0; k < SLOTS; k++) begin
        s = (oldest + k) % SLOTS;
        if (!r.found && held[s] && tag_copy[s] == page) begin
          r.found   = 1'b1;
          r.slot_id = SLOT_ID_W'(s);
        end
      end
    end
    return r;
  endfunction

  // Present one transaction and hold it until in_tready is seen at an edge.
  // tvalid is only lowered when a gap is taken, so back-to-back transactions
  // never see a low/high pair of assignments in one time step.
  task automatic send_request(input logic act, input logic [TAG_W-1:0] page);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= page;
    in_tuser  <= act;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_slot(act, page));
    if (act == ACT_ALLOCATE) n_alloc++;
    else n_lookup++;
  endtask

  // Random traffic over a page pool. Most pages come from the pool so lookups
  // hit and allocates duplicate; pool entries are refreshed now and then, and
  // a fifth of the pages are fresh 32-bit values.
  task automatic run_random(input int count, input int pool_size, input int alloc_pct);
    logic             act;
    logic [TAG_W-1:0] page;
    int               idx;
    for (int i = 0; i < count; i++) begin
      idx = $urandom_range(0, pool_size - 1);
      if ($urandom_range(0, 15) == 0) page_pool[idx] = $urandom;
      act  = ($urandom_range(0, 99) < alloc_pct) ? ACT_ALLOCATE : ACT_LOOKUP;
      page = ($urandom_range(0, 9) < 8) ? page_pool[idx] : $urandom;
      send_request(act, page);
    end
  endtask

  // Lookups on an empty cache must all miss with slot 0.
  task automatic test_miss_on_empty();
    send_request(ACT_LOOKUP, 32'h0000_0000);
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF);
    send_request(ACT_LOOKUP, 32'hA5A5_A5A5);
  endtask

  // Extreme and alternating page numbers, then hits on each and a near miss.
  task automatic test_edge_pages();
    send_request(ACT_ALLOCATE, 32'h0000_0000);
    send_request(ACT_ALLOCATE, 32'hFFFF_FFFF);
    send_request(ACT_ALLOCATE, 32'hAAAA_AAAA);
    send_request(ACT_ALLOCATE, 32'h5555_5555);
    send_request(ACT_LOOKUP,   32'h5555_5555);
    send_request(ACT_LOOKUP,   32'hAAAA_AAAA);
    send_request(ACT_LOOKUP,   32'hFFFF_FFFF);
    send_request(ACT_LOOKUP,   32'h0000_0000);
    send_request(ACT_LOOKUP,   32'h0000_0001);
  endtask

  // Same page in two slots: the lookup must return the older one.
  task automatic test_duplicate_order();
    send_request(ACT_ALLOCATE, 32'h1234_5678);
    send_request(ACT_ALLOCATE, 32'h8765_4321);
    send_request(ACT_ALLOCATE, 32'h1234_5678);
    send_request(ACT_LOOKUP,   32'h1234_5678);
    send_request(ACT_LOOKUP,   32'h8765_4321);
  endtask

  // Broad mix with gaps and stalls; the cache fills, wraps and evicts.
  task automatic test_random_mixed();
    for (int i = 0; i < POOL_DEPTH; i++) page_pool[i] = $urandom;
    page_pool[0] = 32'h0000_0000;
    page_pool[1] = 32'hFFFF_FFFF;
    run_random(500, POOL_DEPTH, 45);
  endtask

  // Tiny pool: many copies of one page across the wrap point, so the
  // oldest-copy rule is exercised with a moving oldest slot.
  task automatic test_random_duplicates();
    run_random(300, 4, 55);
  endtask

  // Final stretch: no sender gaps, no receiver stalls.
  task automatic test_random_back_to_back();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    run_random(250, POOL_DEPTH, 40);
  endtask

  // Receiver: tready low in random bursts while stalls are enabled.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_stalls && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    slot_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: found=%0b slot_id=%0d",
               out_tuser, out_tdata[SLOT_ID_W-1:0]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.found) begin
          $error("found: expected %0b, actual %0b", want.found, out_tuser);
          error_count++;
        end
        if (out_tdata[SLOT_ID_W-1:0] !== want.slot_id) begin
          $error("slot_id: expected %0d, actual %0d", want.slot_id,
                 out_tdata[SLOT_ID_W-1:0]);
          error_count++;
        end
        if (out_tdata[OUT_TDATA_W-1:SLOT_ID_W] !== '0) begin
          $error("tdata_pad: expected 0, actual %0h", out_tdata[OUT_TDATA_W-1:SLOT_ID_W]);
          error_count++;
        end
        if (want.found && n_lookup > 0) n_hit++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= ACT_LOOKUP;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    error_count = 0;
    n_lookup    = 0;
    n_alloc     = 0;
    n_hit       = 0;
    cycle_count = 0;
    alloc_ptr   = 0;
    wrapped     = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      held[i]     = 1'b0;
      tag_copy[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_miss_on_empty();
    test_edge_pages();
    test_duplicate_order();
    test_random_mixed();
    test_random_duplicates();
    test_random_back_to_back();

    // Drain: last transaction was accepted in this step, drop valid once.
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);

    $display("tb: %0d lookups and %0d allocates checked, %0d results with found set",
             n_lookup, n_alloc, n_hit);
    $display("tb: covered empty misses, extreme pages, duplicates across wrap, gaps and stalls");
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
